>>> rtl/eth_ipv4_tcp_header_parser_top_defines.svh
// Assertion macros for the Ethernet/IPv4/TCP header parser
`ifndef ETH_IPV4_TCP_HEADER_PARSER_TOP_DEFINES_SVH
`define ETH_IPV4_TCP_HEADER_PARSER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ETHP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ethp same-cycle check failed");

// next-cycle implication, checked out of reset
`define ETHP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ethp next-cycle check failed");

`endif

>>> rtl/ethp_pkg.sv
// Shared types, constants and helpers for the header parser
package ethp_pkg;

    localparam int unsigned OFFSET_W     = 6;
    localparam int unsigned HDR_BYTES_W  = 6;
    localparam int unsigned RES_DATA_W   = 232;

    localparam logic [OFFSET_W-1:0] ETH_LAST_OFFSET = 6'd13;
    localparam logic [OFFSET_W-1:0] ETH_DMAC_END    = 6'd6;
    localparam logic [OFFSET_W-1:0] ETH_SMAC_END    = 6'd12;
    localparam logic [OFFSET_W-1:0] IP_VER_OFFSET   = 6'd0;
    localparam logic [OFFSET_W-1:0] IP_LEN_HI       = 6'd2;
    localparam logic [OFFSET_W-1:0] IP_LEN_LO       = 6'd3;
    localparam logic [OFFSET_W-1:0] IP_SADDR_START  = 6'd12;
    localparam logic [OFFSET_W-1:0] IP_DADDR_START  = 6'd16;
    localparam logic [OFFSET_W-1:0] IP_DADDR_END    = 6'd20;
    localparam logic [OFFSET_W-1:0] TCP_SPORT_END   = 6'd2;
    localparam logic [OFFSET_W-1:0] TCP_DPORT_END   = 6'd4;
    localparam logic [OFFSET_W-1:0] TCP_DOFF_OFFSET = 6'd12;
    localparam logic [3:0]          MIN_HDR_WORDS   = 4'd5;

    typedef enum logic [2:0] {
        SEC_IDLE,
        SEC_ETH,
        SEC_IP,
        SEC_TCP,
        SEC_PAYLOAD
    } sec_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_LAST   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [47:0]            dest_mac;
        logic [47:0]            source_mac;
        logic [3:0]             ip_version;
        logic [HDR_BYTES_W-1:0] ip_header_bytes;
        logic [31:0]            source_ip;
        logic [31:0]            dest_ip;
        logic [15:0]            source_port;
        logic [15:0]            dest_port;
        logic [HDR_BYTES_W-1:0] tcp_header_bytes;
        logic [15:0]            payload_length;
        logic [7:0]             payload_byte;
    } res_t;

    function automatic logic [HDR_BYTES_W-1:0] hdr_bytes(input logic [3:0] words);
        logic [3:0] w;
        w = (words < MIN_HDR_WORDS) ? MIN_HDR_WORDS : words;
        return {w, 2'b00};
    endfunction

endpackage

>>> rtl/ethp_parser.sv
// Input word register and header/payload parsing state machine
module ethp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_start,
    input  logic              res_room,
    output logic              res_push,
    output ethp_pkg::res_t    res_data
);

    logic                           in_valid_reg, in_valid_next;
    logic [7:0]                     byte_reg;
    logic                           start_reg;
    logic                           advance;

    ethp_pkg::sec_t                 section_reg, section_next, sec_e;
    logic [ethp_pkg::OFFSET_W-1:0]  offset_reg, offset_next, off_e;
    logic [ethp_pkg::OFFSET_W:0]    off_inc;
    logic [47:0]                    dmac_reg, dmac_next, dmac_e;
    logic [47:0]                    smac_reg, smac_next, smac_e;
    logic [3:0]                     ver_reg, ver_next, ver_e;
    logic [3:0]                     ihl_reg, ihl_next, ihl_e;
    logic [15:0]                    tlen_reg, tlen_next, tlen_e;
    logic [31:0]                    sip_reg, sip_next, sip_e;
    logic [31:0]                    dip_reg, dip_next, dip_e;
    logic [15:0]                    sport_reg, sport_next, sport_e;
    logic [15:0]                    dport_reg, dport_next, dport_e;
    logic [3:0]                     doff_reg, doff_next, doff_e;
    logic [15:0]                    left_reg, left_next, left_e;

    logic [ethp_pkg::HDR_BYTES_W-1:0] iph, tcph;
    logic [ethp_pkg::HDR_BYTES_W:0]   hdr_sum;
    logic [16:0]                      diff;
    logic [15:0]                      left_calc, left_dec;
    logic                             emit;

    assign advance  = in_valid_reg && res_room;
    assign in_ready = !in_valid_reg || advance;
    assign res_push = advance && emit;

    always_comb begin
        if (in_valid && in_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (in_valid && in_ready) begin
            byte_reg  <= in_byte;
            start_reg <= in_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            section_reg <= ethp_pkg::SEC_IDLE;
            offset_reg  <= '0;
            left_reg    <= '0;
        end else if (advance) begin
            section_reg <= section_next;
            offset_reg  <= offset_next;
            left_reg    <= left_next;
        end
        if (advance) begin
            dmac_reg  <= dmac_next;
            smac_reg  <= smac_next;
            ver_reg   <= ver_next;
            ihl_reg   <= ihl_next;
            tlen_reg  <= tlen_next;
            sip_reg   <= sip_next;
            dip_reg   <= dip_next;
            sport_reg <= sport_next;
            dport_reg <= dport_next;
            doff_reg  <= doff_next;
        end
    end

    always_comb begin
        sec_e   = start_reg ? ethp_pkg::SEC_ETH : section_reg;
        off_e   = start_reg ? '0 : offset_reg;
        dmac_e  = start_reg ? '0 : dmac_reg;
        smac_e  = start_reg ? '0 : smac_reg;
        ver_e   = start_reg ? '0 : ver_reg;
        ihl_e   = start_reg ? '0 : ihl_reg;
        tlen_e  = start_reg ? '0 : tlen_reg;
        sip_e   = start_reg ? '0 : sip_reg;
        dip_e   = start_reg ? '0 : dip_reg;
        sport_e = start_reg ? '0 : sport_reg;
        dport_e = start_reg ? '0 : dport_reg;
        doff_e  = start_reg ? '0 : doff_reg;
        left_e  = start_reg ? '0 : left_reg;
        off_inc = {1'b0, off_e} + 7'd1;

        section_next = sec_e;
        offset_next  = off_e;
        dmac_next    = dmac_e;
        smac_next    = smac_e;
        ver_next     = ver_e;
        ihl_next     = ihl_e;
        tlen_next    = tlen_e;
        sip_next     = sip_e;
        dip_next     = dip_e;
        sport_next   = sport_e;
        dport_next   = dport_e;
        doff_next    = doff_e;
        left_next    = left_e;
        emit         = 1'b0;
        res_data     = '0;

        iph       = '0;
        tcph      = '0;
        hdr_sum   = '0;
        diff      = '0;
        left_calc = '0;
        left_dec  = left_e - 16'd1;

        unique case (sec_e)
            ethp_pkg::SEC_ETH: begin
                if (off_e < ethp_pkg::ETH_DMAC_END) begin
                    dmac_next = {dmac_e[39:0], byte_reg};
                end else if (off_e < ethp_pkg::ETH_SMAC_END) begin
                    smac_next = {smac_e[39:0], byte_reg};
                end
                if (off_e == ethp_pkg::ETH_LAST_OFFSET) begin
                    section_next = ethp_pkg::SEC_IP;
                    offset_next  = '0;
                end else begin
                    offset_next  = off_inc[ethp_pkg::OFFSET_W-1:0];
                end
            end
            ethp_pkg::SEC_IP: begin
                if (off_e == ethp_pkg::IP_VER_OFFSET) begin
                    ver_next = byte_reg[7:4];
                    ihl_next = byte_reg[3:0];
                end else if (off_e == ethp_pkg::IP_LEN_HI || off_e == ethp_pkg::IP_LEN_LO) begin
                    tlen_next = {tlen_e[7:0], byte_reg};
                end else if (off_e >= ethp_pkg::IP_SADDR_START
                             && off_e < ethp_pkg::IP_DADDR_START) begin
                    sip_next = {sip_e[23:0], byte_reg};
                end else if (off_e >= ethp_pkg::IP_DADDR_START
                             && off_e < ethp_pkg::IP_DADDR_END) begin
                    dip_next = {dip_e[23:0], byte_reg};
                end
                if (off_inc >= {1'b0, ethp_pkg::hdr_bytes(ihl_next)}) begin
                    section_next = ethp_pkg::SEC_TCP;
                    offset_next  = '0;
                end else begin
                    offset_next  = off_inc[ethp_pkg::OFFSET_W-1:0];
                end
            end
            ethp_pkg::SEC_TCP: begin
                if (off_e < ethp_pkg::TCP_SPORT_END) begin
                    sport_next = {sport_e[7:0], byte_reg};
                end else if (off_e < ethp_pkg::TCP_DPORT_END) begin
                    dport_next = {dport_e[7:0], byte_reg};
                end else if (off_e == ethp_pkg::TCP_DOFF_OFFSET) begin
                    doff_next = byte_reg[7:4];
                end
                iph       = ethp_pkg::hdr_bytes(ihl_e);
                tcph      = ethp_pkg::hdr_bytes(doff_next);
                hdr_sum   = {1'b0, iph} + {1'b0, tcph};
                diff      = {1'b0, tlen_e} - {10'd0, hdr_sum};
                left_calc = diff[16] ? 16'd0 : diff[15:0];
                if (off_inc < {1'b0, tcph}) begin
                    offset_next = off_inc[ethp_pkg::OFFSET_W-1:0];
                end else begin
                    emit                      = 1'b1;
                    left_next                 = left_calc;
                    offset_next               = '0;
                    section_next              = (left_calc != 16'd0) ? ethp_pkg::SEC_PAYLOAD
                                                                     : ethp_pkg::SEC_IDLE;
                    res_data.kind             = ethp_pkg::KIND_HEADER;
                    res_data.dest_mac         = dmac_next;
                    res_data.source_mac       = smac_next;
                    res_data.ip_version       = ver_next;
                    res_data.ip_header_bytes  = iph;
                    res_data.source_ip        = sip_next;
                    res_data.dest_ip          = dip_next;
                    res_data.source_port      = sport_next;
                    res_data.dest_port        = dport_next;
                    res_data.tcp_header_bytes = tcph;
                    res_data.payload_length   = left_calc;
                end
            end
            ethp_pkg::SEC_PAYLOAD: begin
                emit = 1'b1;
                if (left_e != 16'd0) begin
                    left_next = left_dec;
                end
                res_data.payload_byte = byte_reg;
                if (left_next == 16'd0) begin
                    res_data.kind = ethp_pkg::KIND_LAST;
                    section_next  = ethp_pkg::SEC_IDLE;
                end else begin
                    res_data.kind = ethp_pkg::KIND_BYTE;
                end
            end
            default: begin
                section_next = ethp_pkg::SEC_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/ethp_out_buf.sv
// Two-entry result buffer decoupling the parser from the output channel
module ethp_out_buf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ethp_pkg::res_t  push_data,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output ethp_pkg::res_t  out_data
);

    ethp_pkg::res_t  entry0_reg, entry0_next;
    ethp_pkg::res_t  entry1_reg, entry1_next;
    logic [1:0]      count_reg, count_next;
    logic            pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry0_reg;
    assign room      = (count_reg != 2'd2);
    assign pop       = out_valid && out_ready;

    always_comb begin
        entry0_next = entry0_reg;
        entry1_next = entry1_reg;
        count_next  = count_reg;
        case ({push, pop})
            2'b11: begin
                if (count_reg == 2'd1) begin
                    entry0_next = push_data;
                end else begin
                    entry0_next = entry1_reg;
                    entry1_next = push_data;
                end
            end
            2'b01: begin
                entry0_next = entry1_reg;
                count_next  = count_reg - 2'd1;
            end
            2'b10: begin
                if (count_reg == 2'd0) begin
                    entry0_next = push_data;
                end else begin
                    entry1_next = push_data;
                end
                count_next = count_reg + 2'd1;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        entry0_reg <= entry0_next;
        entry1_reg <= entry1_next;
    end

endmodule

>>> rtl/eth_ipv4_tcp_header_parser_top.sv
// Top level of the Ethernet/IPv4/TCP header parser
//
//   channel   dir  tdata                         tuser
//   s_        in   [7:0] data_byte               frame_start
//   m_        out  [231:0] header/payload word   [1:0] kind
//
// One input word per cycle while the result buffer has room; a word is held in the
// input register and then pushed into the two-entry result buffer.
// Every frame byte is taken in a single pass through the parser; the header
// word goes out with the last TCP header byte, then one word per payload byte.
// Reset (aresetn low, synchronous) empties both stages and idles the parser.
// s_tready drops only while the input register holds a word and the result
// buffer is full.
`include "eth_ipv4_tcp_header_parser_top_defines.svh"

module eth_ipv4_tcp_header_parser_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tuser,   // frame_start
    output logic         m_tvalid,
    input  logic         m_tready,
    // dest_mac, source_mac, ip_version, ip_header_bytes, source_ip, dest_ip,
    // source_port, dest_port, tcp_header_bytes, payload_length, payload_byte
    output logic [ethp_pkg::RES_DATA_W-1:0] m_tdata,
    output logic [1:0]   m_tuser    // kind
);

    logic            res_room;
    logic            res_push;
    ethp_pkg::res_t  res_data;
    ethp_pkg::res_t  out_data;

    ethp_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_start (s_tuser),
        .res_room (res_room),
        .res_push (res_push),
        .res_data (res_data)
    );

    ethp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .room      (res_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tuser = out_data.kind;
    assign m_tdata = {out_data.payload_byte, out_data.payload_length,
                      out_data.tcp_header_bytes, out_data.dest_port,
                      out_data.source_port, out_data.dest_ip, out_data.source_ip,
                      out_data.ip_header_bytes, out_data.ip_version,
                      out_data.source_mac, out_data.dest_mac};

    `ETHP_ASSERT_IMPLY(a_stall_needs_result, !s_tready, m_tvalid)
    `ETHP_ASSERT_IMPLY(a_header_no_byte, m_tvalid && m_tuser == ethp_pkg::KIND_HEADER, m_tdata[231:224] == 8'd0)
    `ETHP_ASSERT_IMPLY(a_payload_clean, m_tvalid && m_tuser != ethp_pkg::KIND_HEADER, m_tdata[223:0] == '0)
    `ETHP_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready && !s_tready, !s_tready)

endmodule

>>> tb/sv/eth_ipv4_tcp_header_parser_top_tb.sv
// Self-checking testbench for the Ethernet/IPv4/TCP header parser
module eth_ipv4_tcp_header_parser_top_tb;

    localparam int unsigned ETH_LEN      = 14;
    localparam int unsigned MIN_WORDS    = 5;
    localparam int unsigned RAND_BYTES   = 1500;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned HOLD_TRIGGER = 100;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0]                       payload_byte;
        logic [15:0]                      payload_length;
        logic [ethp_pkg::HDR_BYTES_W-1:0] tcp_header_bytes;
        logic [15:0]                      dest_port;
        logic [15:0]                      source_port;
        logic [31:0]                      dest_ip;
        logic [31:0]                      source_ip;
        logic [ethp_pkg::HDR_BYTES_W-1:0] ip_header_bytes;
        logic [3:0]                       ip_version;
        logic [47:0]                      source_mac;
        logic [47:0]                      dest_mac;
    } fields_t;

    typedef struct packed {
        ethp_pkg::kind_t kind;
        fields_t         f;
    } parsed_word_t;

    typedef struct {
        logic [7:0] data;
        logic       start;
        bit         drain;
    } link_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // data_byte
    logic        s_tuser  = 1'b0;    // frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // dest_mac, source_mac, ip_version, ip_header_bytes, source_ip, dest_ip,
    // source_port, dest_port, tcp_header_bytes, payload_length, payload_byte
    logic [ethp_pkg::RES_DATA_W-1:0] m_tdata;
    logic [1:0]  m_tuser;            // kind

    eth_ipv4_tcp_header_parser_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    link_byte_t   link_bytes_q[$];
    parsed_word_t parsed_words_q[$];

    int unsigned cyc        = 0;
    int unsigned rx_words   = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;
    int unsigned mismatches = 0;
    int unsigned headers_seen  = 0;
    int unsigned payload_seen  = 0;
    int unsigned bytes_sent    = 0;
    int unsigned frames_built  = 0;
    wire         calm = (cyc >= 1500) && (cyc < 2500);

    // parser shadow state
    ethp_pkg::sec_t p_sec  = ethp_pkg::SEC_IDLE;
    int unsigned p_off  = 0;
    logic [47:0] p_dmac = '0;
    logic [47:0] p_smac = '0;
    logic [3:0]  p_ver  = '0;
    logic [3:0]  p_ihl  = '0;
    logic [15:0] p_tot  = '0;
    logic [31:0] p_sip  = '0;
    logic [31:0] p_dip  = '0;
    logic [15:0] p_sport = '0;
    logic [15:0] p_dport = '0;
    logic [3:0]  p_doff = '0;
    logic [15:0] p_left = '0;

    parsed_word_t got_word;
    parsed_word_t want_word;
    bit           word_bad;

    function automatic int unsigned hdr_len(input logic [3:0] words);
        return ((words < MIN_WORDS) ? MIN_WORDS : words) * 4;
    endfunction

    task automatic parse_frame_byte(input logic [7:0] b, input logic start);
        parsed_word_t w;
        int unsigned  iph;
        int unsigned  tcph;
        w = '0;
        if (start) begin
            p_off = 0; p_dmac = '0; p_smac = '0; p_ver = '0; p_ihl = '0;
            p_tot = '0; p_sip = '0; p_dip = '0; p_sport = '0; p_dport = '0;
            p_doff = '0; p_left = '0;
            p_sec = ethp_pkg::SEC_ETH;
        end
        case (p_sec)
            ethp_pkg::SEC_ETH: begin
                if (p_off < 6) p_dmac = {p_dmac[39:0], b};
                else if (p_off < 12) p_smac = {p_smac[39:0], b};
                if (p_off + 1 >= ETH_LEN) begin
                    p_sec = ethp_pkg::SEC_IP;
                    p_off = 0;
                end else begin
                    p_off++;
                end
            end
            ethp_pkg::SEC_IP: begin
                if (p_off == 0) begin
                    p_ver = b[7:4];
                    p_ihl = b[3:0];
                end else if (p_off == 2 || p_off == 3) begin
                    p_tot = {p_tot[7:0], b};
                end else if (p_off >= 12 && p_off < 16) begin
                    p_sip = {p_sip[23:0], b};
                end else if (p_off >= 16 && p_off < 20) begin
                    p_dip = {p_dip[23:0], b};
                end
                if (p_off + 1 >= hdr_len(p_ihl)) begin
                    p_sec = ethp_pkg::SEC_TCP;
                    p_off = 0;
                end else begin
                    p_off++;
                end
            end
            ethp_pkg::SEC_TCP: begin
                if (p_off < 2) p_sport = {p_sport[7:0], b};
                else if (p_off < 4) p_dport = {p_dport[7:0], b};
                else if (p_off == 12) p_doff = b[7:4];
                if (p_off + 1 < hdr_len(p_doff)) begin
                    p_off++;
                end else begin
                    iph  = hdr_len(p_ihl);
                    tcph = hdr_len(p_doff);
                    p_left = (p_tot > iph + tcph) ? 16'(p_tot - iph - tcph) : 16'd0;
                    w.kind               = ethp_pkg::KIND_HEADER;
                    w.f.dest_mac         = p_dmac;
                    w.f.source_mac       = p_smac;
                    w.f.ip_version       = p_ver;
                    w.f.ip_header_bytes  = iph[ethp_pkg::HDR_BYTES_W-1:0];
                    w.f.source_ip        = p_sip;
                    w.f.dest_ip          = p_dip;
                    w.f.source_port      = p_sport;
                    w.f.dest_port        = p_dport;
                    w.f.tcp_header_bytes = tcph[ethp_pkg::HDR_BYTES_W-1:0];
                    w.f.payload_length   = p_left;
                    parsed_words_q.push_back(w);
                    p_off = 0;
                    p_sec = (p_left != 0) ? ethp_pkg::SEC_PAYLOAD : ethp_pkg::SEC_IDLE;
                end
            end
            ethp_pkg::SEC_PAYLOAD: begin
                if (p_left != 0) p_left--;
                w.kind = (p_left == 0) ? ethp_pkg::KIND_LAST : ethp_pkg::KIND_BYTE;
                w.f.payload_byte = b;
                parsed_words_q.push_back(w);
                if (p_left == 0) p_sec = ethp_pkg::SEC_IDLE;
            end
            default: ;
        endcase
    endtask

    task automatic add_frame(input logic [47:0] dmac, input logic [47:0] smac,
                             input logic [3:0] ver, input logic [3:0] ihl,
                             input logic [15:0] tot,
                             input logic [31:0] sip, input logic [31:0] dip,
                             input logic [15:0] sport, input logic [15:0] dport,
                             input logic [3:0] doff, input int npay,
                             input int cut, input int junk, input bit drain,
                             output int sent);
        logic [7:0] bytes[$];
        int         iph;
        int         tcph;
        int         n;
        link_byte_t item;
        iph  = hdr_len(ihl);
        tcph = hdr_len(doff);
        for (int i = 0; i < 6; i++) bytes.push_back(dmac[47-8*i -: 8]);
        for (int i = 0; i < 6; i++) bytes.push_back(smac[47-8*i -: 8]);
        bytes.push_back(8'($urandom));
        bytes.push_back(8'($urandom));
        for (int i = 0; i < iph; i++) begin
            if (i == 0) bytes.push_back({ver, ihl});
            else if (i == 2) bytes.push_back(tot[15:8]);
            else if (i == 3) bytes.push_back(tot[7:0]);
            else if (i >= 12 && i < 16) bytes.push_back(sip[31-8*(i-12) -: 8]);
            else if (i >= 16 && i < 20) bytes.push_back(dip[31-8*(i-16) -: 8]);
            else bytes.push_back(8'($urandom));
        end
        for (int i = 0; i < tcph; i++) begin
            if (i == 0) bytes.push_back(sport[15:8]);
            else if (i == 1) bytes.push_back(sport[7:0]);
            else if (i == 2) bytes.push_back(dport[15:8]);
            else if (i == 3) bytes.push_back(dport[7:0]);
            else if (i == 12) bytes.push_back({doff, 4'($urandom)});
            else bytes.push_back(8'($urandom));
        end
        for (int i = 0; i < npay; i++) bytes.push_back(8'($urandom));
        n = (cut >= 0 && cut < bytes.size()) ? cut : bytes.size();
        for (int i = 0; i < n; i++) begin
            item.data  = bytes[i];
            item.start = (i == 0);
            item.drain = drain && (i == 0);
            link_bytes_q.push_back(item);
        end
        for (int i = 0; i < junk; i++) begin
            item.data  = 8'($urandom);
            item.start = 1'b0;
            item.drain = 1'b0;
            link_bytes_q.push_back(item);
        end
        sent = n;
        frames_built++;
    endtask

    always @(posedge aclk) cyc <= cyc + 1;

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_frame_byte(s_tdata, s_tuser);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (link_bytes_q.size() != 0 && (calm || $urandom_range(99) >= 8) &&
                    !(link_bytes_q[0].drain && parsed_words_q.size() != 0)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= link_bytes_q[0].data;
                    s_tuser  <= link_bytes_q[0].start;
                    void'(link_bytes_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && rx_words >= HOLD_TRIGGER) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 8);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_word.kind = ethp_pkg::kind_t'(m_tuser);
            got_word.f    = m_tdata;
            rx_words <= rx_words + 1;
            if (got_word.kind == ethp_pkg::KIND_HEADER) headers_seen++;
            else payload_seen++;
            if (parsed_words_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: kind %0d data %h", m_tuser, m_tdata);
            end else begin
                want_word = parsed_words_q.pop_front();
                word_bad = (got_word.kind !== want_word.kind) ||
                    (got_word.f.dest_mac !== want_word.f.dest_mac) ||
                    (got_word.f.source_mac !== want_word.f.source_mac) ||
                    (got_word.f.ip_version !== want_word.f.ip_version) ||
                    (got_word.f.ip_header_bytes !== want_word.f.ip_header_bytes) ||
                    (got_word.f.source_ip !== want_word.f.source_ip) ||
                    (got_word.f.dest_ip !== want_word.f.dest_ip) ||
                    (got_word.f.source_port !== want_word.f.source_port) ||
                    (got_word.f.dest_port !== want_word.f.dest_port) ||
                    (got_word.f.tcp_header_bytes !== want_word.f.tcp_header_bytes) ||
                    (got_word.f.payload_length !== want_word.f.payload_length) ||
                    (got_word.f.payload_byte !== want_word.f.payload_byte);
                if (word_bad) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: expected kind %0d data %h",
                                 want_word.kind, want_word.f);
                        $display("          actual   kind %0d data %h",
                                 m_tuser, m_tdata);
                    end
                end
            end
        end
    end

    initial begin
        int         sent;
        int         total;
        int         ihl_pick;
        int         doff_pick;
        int         npay;
        int         sum;
        int         tot;
        int         cut;
        link_byte_t item;

        // bytes before any frame start
        for (int i = 0; i < 3; i++) begin
            item.data  = 8'($urandom);
            item.start = 1'b0;
            item.drain = 1'b0;
            link_bytes_q.push_back(item);
        end
        // maximal headers, all-ones fields, short payload, trailing junk
        add_frame('1, '1, 4'hF, 4'hF, 16'd123, '1, '1, '1, '1, 4'hF, 3, -1, 2, 1'b0, sent);
        // all-zero fields, clamped lengths, negative payload
        add_frame('0, '0, 4'h0, 4'h0, 16'd0, '0, '0, '0, '0, 4'h0, 2, -1, 0, 1'b0, sent);
        // short fields clamped, payload exactly zero
        add_frame(48'h0102_0304_0506, 48'h0A0B_0C0D_0E0F, 4'h4, 4'h4, 16'd40,
                  32'hC0A8_0001, 32'h0A00_0001, 16'd80, 16'd443, 4'h1, 0, -1, 1, 1'b0, sent);
        // single payload byte
        add_frame(48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555, 4'h4, 4'h5, 16'd41,
                  32'h8000_0001, 32'h7FFF_FFFE, 16'h8001, 16'h7FFE, 4'h5, 1, -1, 0,
                  1'b0, sent);
        // huge total length, restart mid-payload
        add_frame(48'h1234_5678_9ABC, 48'hFEDC_BA98_7654, 4'h4, 4'h5, 16'hFFFF,
                  32'h1111_2222, 32'h3333_4444, 16'd1, 16'd2, 4'h5, 5, -1, 0, 1'b0, sent);
        // restarts in the Ethernet, IP and TCP sections
        add_frame('1, '1, 4'h4, 4'h5, 16'd60, '1, '1, '1, '1, 4'h5, 20, 7, 0, 1'b0, sent);
        add_frame('1, '1, 4'h4, 4'h7, 16'd60, '1, '1, '1, '1, 4'h5, 20, 20, 0, 1'b0, sent);
        add_frame('1, '1, 4'h4, 4'h5, 16'd60, '1, '1, '1, '1, 4'h6, 20, 40, 0, 1'b0, sent);
        add_frame(48'hDEAD_BEEF_0001, 48'h0000_0000_0001, 4'h4, 4'h5, 16'd44,
                  32'h0102_0304, 32'h0506_0708, 16'd1234, 16'd5678, 4'h5, 4, -1, 3,
                  1'b0, sent);

        total = 0;
        while (total < RAND_BYTES) begin
            ihl_pick  = ($urandom_range(99) < 10) ? $urandom_range(0, 4) :
                        ($urandom_range(99) < 70) ? $urandom_range(5, 6) :
                        $urandom_range(7, 15);
            doff_pick = ($urandom_range(99) < 10) ? $urandom_range(0, 4) :
                        ($urandom_range(99) < 70) ? $urandom_range(5, 6) :
                        $urandom_range(7, 15);
            npay = $urandom_range(0, 24);
            sum  = hdr_len(4'(ihl_pick)) + hdr_len(4'(doff_pick));
            if ($urandom_range(99) < 85) tot = sum + npay;
            else if ($urandom_range(99) < 60) tot = $urandom_range(0, sum);
            else tot = $urandom_range(0, 65535);
            cut = ($urandom_range(99) < 8) ? $urandom_range(1, ETH_LEN + sum) : -1;
            add_frame({16'($urandom), $urandom}, {16'($urandom), $urandom},
                      4'($urandom), 4'(ihl_pick), 16'(tot), $urandom, $urandom,
                      16'($urandom), 16'($urandom), 4'(doff_pick), npay, cut,
                      $urandom_range(0, 2), (total == 0) || ($urandom_range(99) < 5),
                      sent);
            total += sent;
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (link_bytes_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (parsed_words_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        mismatches += parsed_words_q.size();

        $display("Sent %0d bytes in %0d frames; checked %0d header and %0d payload words.",
                 bytes_sent, frames_built, headers_seen, payload_seen);
        $display("Frames covered clamped and maximal headers, empty and negative payloads,");
        $display("restarts in every section, stray bytes and output back-pressure.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout waiting for the parser");
        $display("Some tests failed");
        $finish;
    end

endmodule
